// ----- design/modrm_dec_pkg.sv -----
// ----------------------------------------------------------------------------
// modrm_dec_pkg
// Types and codes that the operand decoder modules share.
// ----------------------------------------------------------------------------
`default_nettype none

package modrm_dec_pkg;

    // format selector
    localparam logic [1:0] FMT_REG_RM = 2'd0;
    localparam logic [1:0] FMT_RM_IMM = 2'd1;
    localparam logic [1:0] FMT_RM     = 2'd2;
    localparam logic [1:0] FMT_BAD    = 2'd3;

    // mod field
    localparam logic [1:0] MOD_NO_DISP = 2'd0;
    localparam logic [1:0] MOD_DISP8   = 2'd1;
    localparam logic [1:0] MOD_DISP16  = 2'd2;
    localparam logic [1:0] MOD_REG     = 2'd3;

    localparam logic [2:0] RM_DIRECT = 3'd6;

    // opcodes of note
    localparam logic [7:0] OPC_GRP1_B   = 8'h80;
    localparam logic [7:0] OPC_GRP1_W   = 8'h81;
    localparam logic [7:0] OPC_GRP1_B82 = 8'h82;
    localparam logic [7:0] OPC_GRP1_SX  = 8'h83;
    localparam logic [7:0] OPC_SHF_0    = 8'hD0;
    localparam logic [7:0] OPC_SHF_1    = 8'hD1;
    localparam logic [7:0] OPC_SHF_2    = 8'hD2;
    localparam logic [7:0] OPC_SHF_3    = 8'hD3;
    localparam logic [7:0] OPC_GRP3_B   = 8'hF6;
    localparam logic [7:0] OPC_GRP3_W   = 8'hF7;
    localparam logic [7:0] OPC_GRP4     = 8'hFE;
    localparam logic [7:0] OPC_GRP5     = 8'hFF;

    // dense group operation codes
    localparam logic [4:0] GOP_ADD  = 5'd0;
    localparam logic [4:0] GOP_ROL  = 5'd8;
    localparam logic [4:0] GOP_SAR  = 5'd14;
    localparam logic [4:0] GOP_TEST = 5'd15;
    localparam logic [4:0] GOP_INC  = 5'd22;
    localparam logic [4:0] GOP_DEC  = 5'd23;
    localparam logic [4:0] GOP_CALL = 5'd24;
    localparam logic [4:0] GOP_JMP  = 5'd25;
    localparam logic [4:0] GOP_PUSH = 5'd26;

    typedef struct packed {
        logic [4:0] group_op;
        logic       error;
    } t_group_res;

    typedef struct packed {
        logic [2:0]  inst_length;
        logic        direct_addr;
        logic [15:0] disp_value;
        logic [15:0] imm_value;
    } t_operand;

endpackage

`default_nettype wire

// ----- design/modrm_dec_group.sv -----
// ----------------------------------------------------------------------------
// modrm_dec_group
// Decodes the extension field of the group opcodes into a dense operation
// code and flags invalid extensions and formats.
// ----------------------------------------------------------------------------
`default_nettype none

module modrm_dec_group
    import modrm_dec_pkg::*;
(
    input  wire logic [7:0] i_opcode,
    input  wire logic [2:0] i_ext,
    input  wire logic [1:0] i_req_type,
    output t_group_res      o_res
);

    logic [4:0] gop;
    logic       bad;
    logic [4:0] ext5;

    assign ext5 = {2'b00, i_ext};

    always_comb begin
        gop = GOP_ADD;
        bad = 1'b0;
        unique case (i_opcode)
            OPC_GRP1_B, OPC_GRP1_W: begin
                gop = ext5;
            end
            OPC_GRP1_B82, OPC_GRP1_SX: begin
                if (i_ext inside {3'd1, 3'd4, 3'd6}) begin
                    bad = 1'b1;
                end else begin
                    gop = ext5;
                end
            end
            OPC_SHF_0, OPC_SHF_1, OPC_SHF_2, OPC_SHF_3: begin
                if (i_ext == 3'd6) begin
                    bad = 1'b1;
                end else if (i_ext == 3'd7) begin
                    gop = GOP_SAR;
                end else begin
                    gop = GOP_ROL + ext5;
                end
            end
            OPC_GRP3_B, OPC_GRP3_W: begin
                if (i_ext == 3'd0) begin
                    gop = GOP_TEST;
                end else if (i_ext == 3'd1) begin
                    bad = 1'b1;
                end else begin
                    gop = GOP_SAR + ext5;
                end
            end
            OPC_GRP4: begin
                if (i_ext == 3'd0) begin
                    gop = GOP_INC;
                end else if (i_ext == 3'd1) begin
                    gop = GOP_DEC;
                end else begin
                    bad = 1'b1;
                end
            end
            OPC_GRP5: begin
                case (i_ext)
                    3'd0:         gop = GOP_INC;
                    3'd1:         gop = GOP_DEC;
                    3'd2, 3'd3:   gop = GOP_CALL;
                    3'd4, 3'd5:   gop = GOP_JMP;
                    3'd6:         gop = GOP_PUSH;
                    default:      bad = 1'b1;
                endcase
            end
            default: begin
                gop = GOP_ADD;
            end
        endcase
    end

    assign o_res.group_op = bad ? GOP_ADD : gop;
    assign o_res.error    = bad || (i_req_type == FMT_BAD);

endmodule

`default_nettype wire

// ----- design/modrm_dec_operand.sv -----
// ----------------------------------------------------------------------------
// modrm_dec_operand
// Works out displacement, immediate and total length from the byte window.
// ----------------------------------------------------------------------------
`default_nettype none

module modrm_dec_operand
    import modrm_dec_pkg::*;
(
    input  wire logic [1:0] i_req_type,
    input  wire logic [7:0] i_opcode,
    input  wire logic [7:0] i_modrm,
    input  wire logic [7:0] i_byte_two,
    input  wire logic [7:0] i_byte_three,
    input  wire logic [7:0] i_byte_four,
    input  wire logic [7:0] i_byte_five,
    output t_operand        o_opd
);

    logic [1:0]  mod_f;
    logic [2:0]  rm_f;
    logic        direct;
    logic [1:0]  disp_len;
    logic [1:0]  imm_len;
    logic [7:0]  imm_lo;
    logic [7:0]  imm_hi;
    logic [15:0] disp_value;
    logic [15:0] imm_value;

    assign mod_f  = i_modrm[7:6];
    assign rm_f   = i_modrm[2:0];
    assign direct = (mod_f == MOD_NO_DISP) && (rm_f == RM_DIRECT);

    always_comb begin
        disp_len   = 2'd0;
        disp_value = 16'h0000;
        if (direct || mod_f == MOD_DISP16) begin
            disp_len   = 2'd2;
            disp_value = {i_byte_three, i_byte_two};
        end else if (mod_f == MOD_DISP8) begin
            disp_len   = 2'd1;
            disp_value = {{8{i_byte_two[7]}}, i_byte_two};
        end
    end

    // immediate follows the displacement
    always_comb begin
        case (disp_len)
            2'd0: begin
                imm_lo = i_byte_two;
                imm_hi = i_byte_three;
            end
            2'd1: begin
                imm_lo = i_byte_three;
                imm_hi = i_byte_four;
            end
            default: begin
                imm_lo = i_byte_four;
                imm_hi = i_byte_five;
            end
        endcase
    end

    always_comb begin
        imm_len   = 2'd0;
        imm_value = 16'h0000;
        if (i_req_type == FMT_RM_IMM) begin
            if (!i_opcode[0]) begin
                imm_len   = 2'd1;
                imm_value = {8'h00, imm_lo};
            end else if (i_opcode == OPC_GRP1_SX) begin
                imm_len   = 2'd1;
                imm_value = {{8{imm_lo[7]}}, imm_lo};
            end else begin
                imm_len   = 2'd2;
                imm_value = {imm_hi, imm_lo};
            end
        end
    end

    assign o_opd = '{
        inst_length: 3'd2 + {1'b0, disp_len} + {1'b0, imm_len},
        direct_addr: direct,
        disp_value:  disp_value,
        imm_value:   imm_value
    };

endmodule

`default_nettype wire

// ----- design/modrm_operand_decoder_8086.sv -----
// ----------------------------------------------------------------------------
// modrm_operand_decoder_8086
// Field, operand and group decoder for one 8086 mod-reg-r/m instruction.
// ----------------------------------------------------------------------------
// The block takes one instruction window every clock cycle; busy never rises.
// A window transferred on start is latched in the input register, decoded in
// one pass of shallow logic and caught in the result register, so its result
// is marked on the o_ ports by o_done for exactly one cycle. Results come out
// in the order the windows went in. The receiver cannot stall the block, so
// it must take every result on the cycle that o_done is high.
`default_nettype none

module modrm_operand_decoder_8086
    import modrm_dec_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [7:0]  i_byte_zero,
    input  wire logic [7:0]  i_byte_one,
    input  wire logic [7:0]  i_byte_two,
    input  wire logic [7:0]  i_byte_three,
    input  wire logic [7:0]  i_byte_four,
    input  wire logic [7:0]  i_byte_five,
    output logic             o_done,
    output logic [2:0]       o_inst_length,
    output logic [1:0]       o_mod_bits,
    output logic [2:0]       o_reg_bits,
    output logic [2:0]       o_rm_bits,
    output logic             o_word_flag,
    output logic             o_reg_is_dest,
    output logic             o_direct_addr,
    output logic signed [15:0] o_disp_value,
    output logic [15:0]      o_imm_value,
    output logic [4:0]       o_group_op,
    output logic             o_decode_error
);

    logic       r_in_valid;
    logic [1:0] r_req_type;
    logic [7:0] r_b0, r_b1, r_b2, r_b3, r_b4, r_b5;

    logic       r_out_valid;
    t_operand   r_opd;
    t_group_res r_grp;
    logic [7:0] r_op;
    logic [7:0] r_modrm;
    logic       r_dbit;

    t_operand   n_opd;
    t_group_res n_grp;
    logic       accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req_type <= i_req_type;
            r_b0       <= i_byte_zero;
            r_b1       <= i_byte_one;
            r_b2       <= i_byte_two;
            r_b3       <= i_byte_three;
            r_b4       <= i_byte_four;
            r_b5       <= i_byte_five;
        end
    end

    modrm_dec_operand u_operand (
        .i_req_type   (r_req_type),
        .i_opcode     (r_b0),
        .i_modrm      (r_b1),
        .i_byte_two   (r_b2),
        .i_byte_three (r_b3),
        .i_byte_four  (r_b4),
        .i_byte_five  (r_b5),
        .o_opd        (n_opd)
    );

    modrm_dec_group u_group (
        .i_opcode   (r_b0),
        .i_ext      (r_b1[5:3]),
        .i_req_type (r_req_type),
        .o_res      (n_grp)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid) begin
            r_opd   <= n_opd;
            r_grp   <= n_grp;
            r_op    <= r_b0;
            r_modrm <= r_b1;
            r_dbit  <= (r_req_type == FMT_REG_RM) && r_b0[1];
        end
    end

    assign o_done         = r_out_valid;
    assign o_inst_length  = r_opd.inst_length;
    assign o_mod_bits     = r_modrm[7:6];
    assign o_reg_bits     = r_modrm[5:3];
    assign o_rm_bits      = r_modrm[2:0];
    assign o_word_flag    = r_op[0];
    assign o_reg_is_dest  = r_dbit;
    assign o_direct_addr  = r_opd.direct_addr;
    assign o_disp_value   = r_opd.disp_value;
    assign o_imm_value    = r_opd.imm_value;
    assign o_group_op     = r_grp.group_op;
    assign o_decode_error = r_grp.error;

    // every transfer yields a result strobe after the input and result registers
    a_done_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> ##1 o_done)
        else $error("result strobe missing after transfer");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(accept, 2))
        else $error("result strobe without a transfer");

    a_length_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_inst_length >= 3'd2 && o_inst_length <= 3'd6))
        else $error("instruction length out of range");

    a_direct_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_direct_addr) |->
            (o_mod_bits == MOD_NO_DISP && o_rm_bits == RM_DIRECT
             && o_inst_length >= 3'd4))
        else $error("direct address flag inconsistent with fields");

    a_group_op_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_group_op <= GOP_PUSH))
        else $error("group operation code out of range");

endmodule

`default_nettype wire
